FILE: design/imc_pkg.sv
// Package for the interval merge / complement block.
// Holds the input and result beat types and the configuration register indexes.
// No dependencies.
package imc_pkg;

  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COMPLEMENT_MODE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DROP_EMPTY      = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIME_FLOOR      = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIME_CEILING    = 2'd3;

  localparam int CFG_DATA_WIDTH = 64;
  localparam int PORT_TIME_WIDTH = 64;

  typedef struct packed {
    logic signed [PORT_TIME_WIDTH-1:0] interval_start;
    logic signed [PORT_TIME_WIDTH-1:0] interval_stop;
    logic                              final_item;
    logic                              no_interval;
  } in_item_t;

  typedef struct packed {
    logic signed [PORT_TIME_WIDTH-1:0] out_start;
    logic signed [PORT_TIME_WIDTH-1:0] out_stop;
    logic                              last_out;
  } out_item_t;

endpackage

FILE: design/imc_core.sv
// Merge / complement core: holds the open run and turns one interval beat into
// zero, one or two result beats. Depends on imc_pkg.
module imc_core #(
  parameter int TIME_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  imc_pkg::in_item_t            item,
  input  logic                         complement_mode,
  input  logic                         drop_empty,
  input  logic signed [TIME_WIDTH-1:0] time_floor,
  input  logic signed [TIME_WIDTH-1:0] time_ceiling,
  output logic [1:0]                   res_cnt,
  output imc_pkg::out_item_t           res0,
  output imc_pkg::out_item_t           res1
);
  import imc_pkg::*;

  logic                         run_open_r, run_open_nxt;
  logic signed [TIME_WIDTH-1:0] run_start_r, run_start_nxt;
  logic signed [TIME_WIDTH-1:0] run_stop_r, run_stop_nxt;

  logic signed [TIME_WIDTH-1:0] s_t, e_t;
  logic                         have;
  out_item_t                    res [2];
  logic [1:0]                   n;

  assign s_t = item.interval_start[TIME_WIDTH-1:0];
  assign e_t = item.interval_stop[TIME_WIDTH-1:0];

  // A dropped empty interval behaves like an end-marker-only beat.
  assign have = !item.no_interval && !(drop_empty && !(s_t < e_t));

  always_comb begin
    run_open_nxt  = run_open_r;
    run_start_nxt = run_start_r;
    run_stop_nxt  = run_stop_r;
    n             = 2'd0;
    res[0]        = '0;
    res[1]        = '0;

    if (have) begin
      if (!run_open_r) begin
        if (complement_mode) begin
          res[0] = '{out_start: PORT_TIME_WIDTH'(time_floor),
                     out_stop: PORT_TIME_WIDTH'(s_t), last_out: 1'b0};
          n = 2'd1;
        end
        run_open_nxt  = 1'b1;
        run_start_nxt = s_t;
        run_stop_nxt  = e_t;
      end else if (!(run_stop_r < s_t)) begin
        if (run_stop_r < e_t) begin
          run_stop_nxt = e_t;
        end
      end else begin
        if (complement_mode) begin
          res[0] = '{out_start: PORT_TIME_WIDTH'(run_stop_r),
                     out_stop: PORT_TIME_WIDTH'(s_t), last_out: 1'b0};
        end else begin
          res[0] = '{out_start: PORT_TIME_WIDTH'(run_start_r),
                     out_stop: PORT_TIME_WIDTH'(run_stop_r), last_out: 1'b0};
        end
        n = 2'd1;
        run_start_nxt = s_t;
        run_stop_nxt  = e_t;
      end
    end

    if (item.final_item) begin
      if (run_open_nxt) begin
        if (complement_mode) begin
          res[n[0]] = '{out_start: PORT_TIME_WIDTH'(run_stop_nxt),
                        out_stop: PORT_TIME_WIDTH'(time_ceiling), last_out: 1'b1};
        end else begin
          res[n[0]] = '{out_start: PORT_TIME_WIDTH'(run_start_nxt),
                        out_stop: PORT_TIME_WIDTH'(run_stop_nxt), last_out: 1'b1};
        end
        n = n + 2'd1;
      end else if (complement_mode) begin
        res[n[0]] = '{out_start: PORT_TIME_WIDTH'(time_floor),
                      out_stop: PORT_TIME_WIDTH'(time_ceiling), last_out: 1'b1};
        n = n + 2'd1;
      end
      run_open_nxt = 1'b0;
    end
  end

  assign res_cnt = go ? n : 2'd0;
  assign res0    = res[0];
  assign res1    = res[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r  <= 1'b0;
      run_start_r <= '0;
      run_stop_r  <= '0;
    end else if (go) begin
      run_open_r  <= run_open_nxt;
      run_start_r <= run_start_nxt;
      run_stop_r  <= run_stop_nxt;
    end
  end

  // Only the end of a list can add a second result, and it is the closing one.
  a_two_results_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res_cnt == 2'd2) |-> (res1.last_out && !res0.last_out && item.final_item))
    else $error("two results without closing last_out");

  a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (go && item.final_item) |=> !run_open_r)
    else $error("run left open after end of list");

  a_first_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (go && have && !item.final_item) |=> run_open_r)
    else $error("interval did not open a run");

endmodule

FILE: design/imc_outq.sv
// Three-entry result queue: takes up to two result beats per cycle from the
// core and hands out one per cycle while out_stall is low. Depends on imc_pkg.
module imc_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_n,
  input  imc_pkg::out_item_t push0,
  input  imc_pkg::out_item_t push1,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output imc_pkg::out_item_t out_data
);
  import imc_pkg::*;

  localparam logic [1:0] LAST_SLOT = 2'd2;

  out_item_t  q_r [3];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [1:0] count_r, count_nxt;
  logic [1:0] wp_plus1;
  logic       pop;

  function automatic logic [1:0] slot_inc(input logic [1:0] p);
    slot_inc = (p == LAST_SLOT) ? 2'd0 : p + 2'd1;
  endfunction

  // Room for a full pair regardless of what leaves this cycle.
  assign room      = (count_r <= 2'd1);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = q_r[rp_r];
  assign pop       = out_valid && !out_stall;
  assign wp_plus1  = slot_inc(wp_r);

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = pop ? slot_inc(rp_r) : rp_r;
    count_nxt = count_r + push_n - {1'b0, pop};
    if (push_n == 2'd1) begin
      wp_nxt = wp_plus1;
    end else if (push_n == 2'd2) begin
      wp_nxt = slot_inc(wp_plus1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= 2'd0;
      rp_r    <= 2'd0;
      count_r <= 2'd0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wp_r] <= push0;
    end
    if (push_n == 2'd2) begin
      q_r[wp_plus1] <= push1;
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> (count_r <= 2'd1))
    else $error("result queue overrun");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == 2'($past(count_r) + $past(push_n) - {1'b0, $past(pop)})))
    else $error("result queue count mismatch");

endmodule

FILE: design/interval_merge_complement.sv
// Interval merge / complement: sorted interval beats in, merged runs or gaps out.
// The input beat is registered, then its results are written into the result queue.
// Throughput: one input beat per cycle while the result queue has room for a pair;
// two results closing a list can stall the input; the queue drains at most one a cycle.
// Reset (synchronous, rst_n low): no run open, queue empty, config to defaults.
module interval_merge_complement #(
  parameter int TIME_WIDTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  imc_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output imc_pkg::out_item_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [imc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [imc_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);
  import imc_pkg::*;

  localparam logic [TIME_WIDTH-1:0] TIME_MIN = {1'b1, {(TIME_WIDTH-1){1'b0}}};
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};

  logic                         complement_mode_r;
  logic                         drop_empty_r;
  logic signed [TIME_WIDTH-1:0] time_floor_r;
  logic signed [TIME_WIDTH-1:0] time_ceiling_r;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      go;
  logic      room;
  logic [1:0] res_cnt;
  out_item_t res0, res1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      complement_mode_r <= 1'b0;
      drop_empty_r      <= 1'b0;
      time_floor_r      <= TIME_MIN;
      time_ceiling_r    <= TIME_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COMPLEMENT_MODE: complement_mode_r <= cfg_wdata[0];
        CFG_DROP_EMPTY:      drop_empty_r      <= cfg_wdata[0];
        CFG_TIME_FLOOR:      time_floor_r      <= cfg_wdata[TIME_WIDTH-1:0];
        CFG_TIME_CEILING:    time_ceiling_r    <= cfg_wdata[TIME_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // The input register drains into the core whenever the queue has room for a pair.
  assign go       = s1_valid_r && room;
  assign in_stall = s1_valid_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

  imc_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .go              (go),
    .item            (s1_item_r),
    .complement_mode (complement_mode_r),
    .drop_empty      (drop_empty_r),
    .time_floor      (time_floor_r),
    .time_ceiling    (time_ceiling_r),
    .res_cnt         (res_cnt),
    .res0            (res0),
    .res1            (res1)
  );

  imc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (res_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: tb/interval_merge_complement_tb.sv
`timescale 1ns / 100ps
// Testbench for interval_merge_complement: sorted interval lists in, merged runs or gaps out.
// Predicts every result beat from its own copy of the merge state and configuration.
// Depends on imc_pkg and the interval_merge_complement RTL.
module interval_merge_complement_tb;
  import imc_pkg::*;

  localparam int TW = 64;
  localparam logic signed [63:0] T_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] T_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int HOLD_CYCLES = 400;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;

  // Predicted configuration and merge state.
  logic mode_gaps;
  logic skip_empty;
  logic signed [63:0] floor_t;
  logic signed [63:0] ceil_t;
  logic run_open_q;
  logic signed [63:0] run_lo;
  logic signed [63:0] run_hi;
  logic signed [63:0] gap_lo;

  out_item_t pending_runs[$];
  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 4;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;

  interval_merge_complement #(.TIME_WIDTH(TW)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [63:0] norm_t(logic [63:0] v);
    logic signed [TW-1:0] t;
    t = v[TW-1:0];
    return t;
  endfunction

  function automatic in_item_t iv(logic [63:0] s, logic [63:0] e, logic fin, logic none);
    in_item_t it;
    it.interval_start = s;
    it.interval_stop = e;
    it.final_item = fin;
    it.no_interval = none;
    return it;
  endfunction

  function automatic void queue_run(logic signed [63:0] s, logic signed [63:0] e, logic last);
    out_item_t r;
    r.out_start = s;
    r.out_stop = e;
    r.last_out = last;
    pending_runs.push_back(r);
  endfunction

  task automatic predict_runs(in_item_t it);
    logic signed [63:0] s;
    logic signed [63:0] e;
    bit has_iv;
    s = norm_t(it.interval_start);
    e = norm_t(it.interval_stop);
    has_iv = !it.no_interval;
    if (has_iv && skip_empty && !(s < e)) has_iv = 1'b0;
    if (has_iv) begin
      if (!run_open_q) begin
        // The gap in front of the first interval goes out at once, even when empty.
        if (mode_gaps) queue_run(floor_t, s, 1'b0);
        run_open_q = 1'b1;
        run_lo = s;
        run_hi = e;
      end else if (!(run_hi < s)) begin
        if (run_hi < e) run_hi = e;
      end else begin
        gap_lo = run_hi;
        if (mode_gaps) queue_run(gap_lo, s, 1'b0);
        else queue_run(run_lo, run_hi, 1'b0);
        run_lo = s;
        run_hi = e;
      end
    end
    if (it.final_item) begin
      if (run_open_q) begin
        gap_lo = run_hi;
        if (mode_gaps) queue_run(gap_lo, ceil_t, 1'b1);
        else queue_run(run_lo, run_hi, 1'b1);
      end else if (mode_gaps) begin
        queue_run(floor_t, ceil_t, 1'b1);
      end
      run_open_q = 1'b0;
    end
  endtask

  // Result check first, then configuration and input beats of the same edge.
  always @(posedge clk) begin : scoreboard
    out_item_t want;
    if (!rst_n) begin
      mode_gaps = 1'b0;
      skip_empty = 1'b0;
      floor_t = norm_t(T_MIN);
      ceil_t = norm_t(T_MAX);
      run_open_q = 1'b0;
      run_lo = '0;
      run_hi = '0;
      gap_lo = '0;
      pending_runs.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_runs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: start %0d stop %0d last %0b",
                     out_data.out_start, out_data.out_stop, out_data.last_out);
        end else begin
          want = pending_runs.pop_front();
          if (out_data.out_start !== want.out_start || out_data.out_stop !== want.out_stop ||
              out_data.last_out !== want.last_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: start %0d/%0d stop %0d/%0d last %0b/%0b (exp/got)",
                       want.out_start, out_data.out_start, want.out_stop, out_data.out_stop,
                       want.last_out, out_data.last_out);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_COMPLEMENT_MODE: mode_gaps = cfg_wdata[0];
          CFG_DROP_EMPTY:      skip_empty = cfg_wdata[0];
          CFG_TIME_FLOOR:      floor_t = norm_t(cfg_wdata);
          CFG_TIME_CEILING:    ceil_t = norm_t(cfg_wdata);
          default: ;
        endcase
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) predict_runs(in_data);
    end
  end

  // The receiver switches at random among its stall patterns; a hold request stalls it outright.
  always @(negedge clk) begin : receiver
    static rx_mode_t rx_mode = RX_FREE;
    static int mode_left = 0;
    static int hold_left = 0;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE:   out_stall <= 1'b0;
        RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
        RX_TOGGLE: out_stall <= !out_stall;
        default:   out_stall <= 1'b0;
      endcase
    end
  end

  // Offers one beat, waits for it to be taken, and ends a burst with a gap now and then.
  task automatic send_item(in_item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        in_data <= iv(rand64(), rand64(), 1'($urandom), 1'($urandom));
        repeat ($urandom_range(0, 5)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_runs.size() != 0) @(posedge clk);
    // Items that close nothing may still be in flight.
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(bit gaps, bit drop, logic [63:0] fl, logic [63:0] cl);
    wait_quiet();
    write_reg(CFG_COMPLEMENT_MODE, {63'(rand64()), gaps});
    write_reg(CFG_DROP_EMPTY, {63'(rand64()), drop});
    write_reg(CFG_TIME_FLOOR, fl);
    write_reg(CFG_TIME_CEILING, cl);
  endtask

  // Mostly sorted lists with random content; some touching, unsorted, empty and
  // reversed intervals, stray beats with neither interval nor end marker, and separate end markers.
  task automatic run_lists(int n);
    int target;
    int len;
    int pick;
    bit close_inline;
    logic [63:0] base, s, e, cur, hi;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
      close_inline = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: base = rand64();
        1: base = T_MIN + 64'($urandom_range(0, 50));
        2: base = T_MAX - 64'($urandom_range(200, 2000));
        default: base = 64'($urandom_range(0, 2000)) - 64'd1000;
      endcase
      cur = base;
      hi = base;
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 15);
        if (k == 0) s = base;
        else if (pick <= 1) s = hi;
        else if (pick == 2) s = hi + 64'd1;
        else if (pick == 3) s = cur - 64'($urandom_range(1, 10));
        else if (pick == 4) s = cur + 64'($urandom);
        else s = cur + 64'($urandom_range(0, 30));
        case ($urandom_range(0, 9))
          0: e = s;
          1: e = s - 64'($urandom_range(1, 50));
          2: e = s + 64'($urandom);
          default: e = s + 64'($urandom_range(1, 40));
        endcase
        if ($urandom_range(0, 19) == 0) send_item(iv(rand64(), rand64(), 1'b0, 1'b1));
        send_item(iv(s, e, close_inline && (k == len - 1), 1'b0));
        cur = s;
        if (k == 0 || $signed(e) > $signed(hi)) hi = e;
      end
      if (len == 0 || !close_inline) send_item(iv(rand64(), rand64(), 1'b1, 1'b1));
    end
  endtask

  task automatic test_reset_defaults();
    // Merge mode out of reset; then the empty list shows the reset floor and ceiling.
    send_item(iv(T_MIN, T_MAX, 1'b1, 1'b0));
    wait_quiet();
    write_reg(CFG_COMPLEMENT_MODE, 64'd1);
    send_item(iv(rand64(), rand64(), 1'b1, 1'b1));
  endtask

  task automatic test_merge_runs();
    configure(1'b0, 1'b0, T_MIN, T_MAX);
    send_item(iv(64'd10, 64'd20, 1'b0, 1'b0));
    send_item(iv(64'd15, 64'd25, 1'b0, 1'b0));
    send_item(iv(64'd25, 64'd30, 1'b0, 1'b0));
    send_item(iv(T_MAX, T_MIN, 1'b0, 1'b1));
    send_item(iv(64'd5, 64'd12, 1'b0, 1'b0));
    send_item(iv(64'd31, 64'd31, 1'b0, 1'b0));
    send_item(iv(64'd40, 64'd35, 1'b0, 1'b0));
    send_item(iv(64'd50, 64'd60, 1'b1, 1'b0));
  endtask

  task automatic test_complement_gaps();
    configure(1'b1, 1'b0, 64'd0, 64'd1000);
    send_item(iv(64'd0, 64'd10, 1'b0, 1'b0));
    send_item(iv(64'd20, 64'd30, 1'b0, 1'b0));
    send_item(iv(64'd30, 64'd40, 1'b1, 1'b0));
    send_item(iv(64'd0, 64'd0, 1'b1, 1'b1));
    configure(1'b1, 1'b0, T_MIN, T_MAX);
    send_item(iv(T_MIN, T_MAX, 1'b1, 1'b0));
  endtask

  task automatic test_drop_empty();
    configure(1'b1, 1'b1, -64'sd500, 64'd500);
    send_item(iv(64'd100, 64'd100, 1'b0, 1'b0));
    send_item(iv(64'd50, 64'd40, 1'b0, 1'b0));
    send_item(iv(64'd200, 64'd300, 1'b0, 1'b0));
    // A dropped interval still ends its list.
    send_item(iv(64'd300, 64'd300, 1'b1, 1'b0));
    send_item(iv(64'd7, 64'd3, 1'b1, 1'b0));
  endtask

  task automatic test_random_lists();
    configure(1'b0, 1'b0, T_MIN, T_MAX);
    run_lists(300);
    configure(1'b1, 1'b0, T_MIN, T_MAX);
    run_lists(300);
    configure(1'b0, 1'b1, rand64(), rand64());
    run_lists(250);
    configure(1'b1, 1'b1, rand64(), rand64());
    run_lists(300);
    configure(1'b1, 1'b0, T_MAX, T_MIN);
    run_lists(200);
    configure(1'b1, 1'b1, 64'd0, 64'd0);
    run_lists(150);
  endtask

  task automatic test_backpressure();
    configure(1'b1, 1'b0, rand64(), rand64());
    gaps_on = 1'b0;
    hold_req = 1'b1;
    run_lists(250);
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_merge_runs();
    test_complement_gaps();
    test_drop_empty();
    test_random_lists();
    test_backpressure();
    wait_quiet();
    if (mismatches == 0 && pending_runs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
